// ===== hw/rtl/hwcc_pkg.sv =====
package hwcc_pkg;

  // Temperatures in tenths of a degree
  typedef logic signed [11:0] temp_t;
  // Compare width: a 12-bit sample, a 10-bit threshold or a threshold minus a margin
  typedef logic signed [12:0] cmp_t;
  typedef logic [9:0]  thr_t;
  typedef logic [8:0]  runon_t;
  typedef logic [15:0] count_t;
  typedef logic [2:0]  cfg_index_t;
  typedef logic [9:0]  cfg_data_t;

  localparam cfg_index_t REG_BEGIN_TEMP       = 3'd0;
  localparam cfg_index_t REG_END_TEMP         = 3'd1;
  localparam cfg_index_t REG_SOLAR_BEGIN_TEMP = 3'd2;
  localparam cfg_index_t REG_LEGIONELLA_TEMP  = 3'd3;
  localparam cfg_index_t REG_FEED_NEEDED_TEMP = 3'd4;
  localparam cfg_index_t REG_RUNON_MINUTES    = 3'd5;

  localparam thr_t       BEGIN_TEMP_RST       = 10'd450;
  localparam thr_t       END_TEMP_RST         = 10'd550;
  localparam thr_t       SOLAR_BEGIN_TEMP_RST = 10'd500;
  localparam thr_t       LEGIONELLA_TEMP_RST  = 10'd700;
  localparam thr_t       FEED_NEEDED_TEMP_RST = 10'd600;
  localparam logic [7:0] RUNON_MINUTES_RST    = 8'd5;

  localparam cmp_t   BOTH_FAULT_TEMP  = 13'sd1000;
  localparam cmp_t   LEGIO_BEGIN_DROP = 13'sd20;
  localparam cmp_t   FEED_MARGIN      = 13'sd50;
  localparam count_t COUNT_MAX        = 16'hFFFF;

  typedef struct packed {
    temp_t      temp_upper;
    logic       upper_fault;
    temp_t      temp_lower;
    logic       lower_fault;
    temp_t      feed_temp;
    logic       feed_fault;
    logic       legionella_on;
    logic       solar_charging;
    logic       manual_mode;
    logic       manual_valve;
  } item_t;

  typedef struct packed {
    thr_t       begin_temp;
    thr_t       end_temp;
    thr_t       solar_begin_temp;
    thr_t       legionella_temp;
    thr_t       feed_needed_temp;
    logic [7:0] runon_minutes;
  } cfg_t;

  typedef struct packed {
    logic   charge;
    logic   valve;
    logic   solar;
    runon_t runon;
    count_t starts;
    count_t hours;
  } state_t;

endpackage

// ===== hw/rtl/hwcc_step.sv =====
module hwcc_step #(
  parameter int TICKS_PER_HOUR = 120,
  localparam int TICK_W = $clog2(TICKS_PER_HOUR + 2)
) (
  input  hwcc_pkg::item_t    item,
  input  hwcc_pkg::cfg_t     cfg,
  input  hwcc_pkg::state_t   state,
  input  logic [TICK_W-1:0]  tick,
  output hwcc_pkg::state_t   state_next,
  output logic [TICK_W-1:0]  tick_next
);
  import hwcc_pkg::*;

  cmp_t              up;
  cmp_t              lo;
  cmp_t              feed;
  cmp_t              feed_lim;
  cmp_t              thr_beg;
  cmp_t              thr_end;
  cmp_t              tmax;
  cmp_t              tmin;
  logic [TICK_W-1:0] tick_inc;

  assign up       = cmp_t'(item.temp_upper);
  assign lo       = cmp_t'(item.temp_lower);
  assign feed     = cmp_t'(item.feed_temp);
  assign feed_lim = cmp_t'({3'b000, cfg.feed_needed_temp}) - FEED_MARGIN;
  assign tick_inc = tick + TICK_W'(1);

  always_comb begin
    state_next = state;
    tick_next  = tick;

    if (item.manual_mode) begin
      state_next.valve = item.manual_valve;
    end else begin
      // count charge time against the old charge bit
      if (state.charge) begin
        if (tick_inc > TICK_W'(TICKS_PER_HOUR)) begin
          tick_next = '0;
          if (state.hours != COUNT_MAX) begin
            state_next.hours = state.hours + 16'd1;
          end
        end else begin
          tick_next = tick_inc;
        end
      end
      if (item.solar_charging) begin
        state_next.valve = 1'b1;
      end else if (state.charge && (item.feed_fault || feed > feed_lim)) begin
        state_next.valve = 1'b1;
      end else if (!item.legionella_on) begin
        if (state.runon != '0) begin
          state_next.runon = state.runon - 9'd1;
        end else begin
          state_next.valve = 1'b0;
        end
      end
    end

    if (item.legionella_on) begin
      thr_end = cmp_t'({3'b000, cfg.legionella_temp});
      thr_beg = thr_end - LEGIO_BEGIN_DROP;
    end else begin
      thr_end = cmp_t'({3'b000, cfg.end_temp});
      thr_beg = cmp_t'({3'b000, cfg.begin_temp});
    end

    // a faulty sensor drops out; with both faulty assume a full tank
    if (!item.upper_fault && !item.lower_fault) begin
      tmax = (up >= lo) ? up : lo;
      tmin = (up >= lo) ? lo : up;
    end else if (!item.upper_fault) begin
      tmax = up;
      tmin = up;
    end else if (!item.lower_fault) begin
      tmax = lo;
      tmin = lo;
    end else begin
      tmax = BOTH_FAULT_TEMP;
      tmin = BOTH_FAULT_TEMP;
    end

    if (tmin > thr_end) begin
      state_next.charge = 1'b0;
      if (!item.legionella_on) begin
        state_next.solar = 1'b0;
      end
    end else begin
      if (tmax < thr_beg) begin
        if (!state.charge) begin
          state_next.charge = 1'b1;
          if (state.starts != COUNT_MAX) begin
            state_next.starts = state.starts + 16'd1;
          end
        end
        state_next.runon = {cfg.runon_minutes, 1'b0};
      end
      if (tmax < cmp_t'({3'b000, cfg.solar_begin_temp})) begin
        state_next.solar = 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hot_water_charge_control_top.sv =====
// Hot-water tank charge control, one item per control tick. Each item carries
// the upper/lower tank temperatures, the boiler feed temperature (signed tenths of a
// degree) with fault flags, and the legionella, solar and manual-mode inputs; each item
// yields exactly one result item with the load valve command, the charge request, the
// solar start flag, the remaining run-on ticks and the saturating start and charge-hour
// counters. The block takes one item per clock cycle while results are taken; an accepted
// item passes from the input register through the tick logic into the state registers,
// which double as the result register. Thresholds must be written through the cfg_write
// port only while no item is in flight; the block does not enforce this. An out-of-range
// index is ignored. TICKS_PER_HOUR + 1 charging ticks make one counted hour.
module hot_water_charge_control_top #(
  parameter int TICKS_PER_HOUR = 120
) (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_write,
  input  hwcc_pkg::cfg_index_t    cfg_index,
  input  hwcc_pkg::cfg_data_t     cfg_data,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  hwcc_pkg::temp_t         temp_upper,
  input  logic                    upper_fault,
  input  hwcc_pkg::temp_t         temp_lower,
  input  logic                    lower_fault,
  input  hwcc_pkg::temp_t         feed_temp,
  input  logic                    feed_fault,
  input  logic                    legionella_on,
  input  logic                    solar_charging,
  input  logic                    manual_mode,
  input  logic                    manual_valve,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    valve_open,
  output logic                    charge_active,
  output logic                    solar_start,
  output hwcc_pkg::runon_t        runon_left,
  output hwcc_pkg::count_t        start_total,
  output hwcc_pkg::count_t        hours_total
);
  import hwcc_pkg::*;

  localparam int TICK_W = $clog2(TICKS_PER_HOUR + 2);

  cfg_t              cfg;
  item_t             item;
  logic              item_valid;
  logic              advance;
  state_t            state;
  state_t            state_next;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;

  // Configuration registers: plain writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.begin_temp       <= BEGIN_TEMP_RST;
      cfg.end_temp         <= END_TEMP_RST;
      cfg.solar_begin_temp <= SOLAR_BEGIN_TEMP_RST;
      cfg.legionella_temp  <= LEGIONELLA_TEMP_RST;
      cfg.feed_needed_temp <= FEED_NEEDED_TEMP_RST;
      cfg.runon_minutes    <= RUNON_MINUTES_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BEGIN_TEMP:       cfg.begin_temp       <= cfg_data;
        REG_END_TEMP:         cfg.end_temp         <= cfg_data;
        REG_SOLAR_BEGIN_TEMP: cfg.solar_begin_temp <= cfg_data;
        REG_LEGIONELLA_TEMP:  cfg.legionella_temp  <= cfg_data;
        REG_FEED_NEEDED_TEMP: cfg.feed_needed_temp <= cfg_data;
        REG_RUNON_MINUTES:    cfg.runon_minutes    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance the held item into the state when the result slot is free or being taken;
  // the input register refills in the same cycle, so unstalled items flow one per cycle.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register: control bit reset, payload plain
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.temp_upper     <= temp_upper;
      item.upper_fault    <= upper_fault;
      item.temp_lower     <= temp_lower;
      item.lower_fault    <= lower_fault;
      item.feed_temp      <= feed_temp;
      item.feed_fault     <= feed_fault;
      item.legionella_on  <= legionella_on;
      item.solar_charging <= solar_charging;
      item.manual_mode    <= manual_mode;
      item.manual_valve   <= manual_valve;
    end
  end

  // One control tick: hysteresis, valve, run-on and counters
  hwcc_step #(
    .TICKS_PER_HOUR(TICKS_PER_HOUR)
  ) u_step (
    .item      (item),
    .cfg       (cfg),
    .state     (state),
    .tick      (tick_count),
    .state_next(state_next),
    .tick_next (tick_count_next)
  );

  // State registers: they change only when an item advances, so they also hold
  // the result steady while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        state      <= state_next;
        tick_count <= tick_count_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign valve_open    = state.valve;
  assign charge_active = state.charge;
  assign solar_start   = state.solar;
  assign runon_left    = state.runon;
  assign start_total   = state.starts;
  assign hours_total   = state.hours;

`ifndef SYNTHESIS
  // The hour prescaler never passes its terminal count
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_count <= TICK_W'(TICKS_PER_HOUR))
    else $error("tick_count beyond TICKS_PER_HOUR");

  // The hour counter never goes backward
  a_hours_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> hours_total >= $past(hours_total))
    else $error("hours_total decreased");

  // Every new charge request counts a start unless the counter is saturated
  a_start_counted: assert property (@(posedge clk) disable iff (rst)
    (!rst ##1 $rose(state.charge)) |->
      (start_total != $past(start_total)) || (start_total == COUNT_MAX))
    else $error("charge start not counted");

  // State changes only when an item advances
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !advance) |=> $stable(state))
    else $error("state changed without an item");
`endif

endmodule
